>>> design/cbes_pkg.sv
// Shared constants and types for the cubic Bezier evaluate and split unit
`timescale 1ns / 1ps

package cbes_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int T_FRAC_BITS = 16;

	localparam int NUM_POINTS = 4;
	localparam int NUM_AXES   = 3;
	localparam int IDX_W      = 2;                       // register index width
	localparam int REG_W      = NUM_AXES * COORD_WIDTH;  // packed z, y, x

	localparam int TW  = T_FRAC_BITS + 1;                // t and 1-t, Q1.f
	localparam int SW  = 2 * TW;                         // u*t, t*t, u*u
	localparam int NSH = 3 * T_FRAC_BITS;                // weights sum to 2^NSH
	localparam int WW  = NSH + 1;                        // weight width
	localparam int PW  = WW + COORD_WIDTH;               // weight * coordinate
	localparam int AW  = PW + 2;                         // sum of four products

	localparam logic [COORD_WIDTH-1:0] CBIAS = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Weight set applied to the four control points
	typedef enum logic [2:0] {
		K_PASS0 = 3'd0,
		K_LIN1  = 3'd1,
		K_QUAD1 = 3'd2,
		K_CUB   = 3'd3,
		K_QUAD2 = 3'd4,
		K_LIN2  = 3'd5,
		K_PASS3 = 3'd6
	} slot_kind_t;

	typedef enum logic {
		CMD_EVAL  = 1'b0,
		CMD_SPLIT = 1'b1
	} cmd_t;

	// Result labels that ride along the pipeline
	typedef struct packed {
		logic             half;
		logic [IDX_W-1:0] idx;
		logic             last;
	} tag_t;

endpackage

>>> design/cbes_req_if.sv
// Request channel: command and curve parameter
`timescale 1ns / 1ps

interface cbes_req_if;
	import cbes_pkg::*;

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [T_FRAC_BITS:0] param_t;

	modport source (output valid, cmd, param_t, input ready);
	modport sink   (input valid, cmd, param_t, output ready);
endinterface

>>> design/cbes_rsp_if.sv
// Result channel: one curve or control point with its labels
`timescale 1ns / 1ps

interface cbes_rsp_if;
	import cbes_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic                          half_select;
	logic [IDX_W-1:0]              point_index;
	logic                          last_result;

	modport source (output valid, coord_x, coord_y, coord_z, half_select, point_index,
		last_result, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, half_select, point_index,
		last_result, output ready);
endinterface

>>> design/cubic_bezier_eval_split.sv
// Top level: cubic Bezier evaluation and de Casteljau split, five-stage pipeline
`timescale 1ns / 1ps

// Usage
//   cfg_we/cfg_index/cfg_wdata write control points P0..P3 (packed z, y, x).
//   Write them only while the unit is idle; stages read the registers live.
//   request: valid/ready transaction carrying cmd (0 evaluate, 1 split) and
//   param_t (Q1.16, values above 1.0 are clamped to 1.0).
//   result: valid/ready transaction per output point with half_select,
//   point_index and last_result labels.
// Throughput
//   Evaluate: one transaction per cycle while result.ready keeps the pipeline moving.
//   Split: stage 1 expands each transaction into eight slots and holds request.ready low
//   meanwhile, so it takes no new request until the last slot moves on.
// Stages
//   Each result passes, in order, through s1 expand, s2 t products, s3 weights,
//   s4 point products and s5 sum/round.
// Reset
//   arst_n clears all valid bits and the control points to zero.
// Stall
//   Each stage has its own ready, so bubbles close up while result.ready is low
//   and the pipeline keeps taking requests until every stage is full.

module cubic_bezier_eval_split (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cbes_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cbes_pkg::REG_W-1:0]     cfg_wdata,
	cbes_req_if.sink                       request,
	cbes_rsp_if.source                     result
);
	import cbes_pkg::*;

	localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam logic [WW-1:0] W_ONE = {1'b1, {NSH{1'b0}}};
	localparam logic [AW-1:0] RND   = {{(AW-NSH){1'b0}}, 1'b1, {(NSH-1){1'b0}}};
	localparam int            VW    = AW - NSH;
	localparam logic [2:0]    CNT_LAST = 3'd7;

	// control point registers
	logic [REG_W-1:0] ctrl_q [NUM_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POINTS; i++) ctrl_q[i] <= '0;
		end else if (cfg_we) begin
			ctrl_q[cfg_index] <= cfg_wdata;
		end
	end

	// stage valids and per-stage ready (bubbles collapse)
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5 = !v_s5 || result.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;

	// ---------------- stage 1: request register and split expander ----------------
	logic          cmd_s1;
	logic [TW-1:0] t_s1, u_s1;
	logic [2:0]    cnt_s1;
	logic [TW-1:0] t_in;
	logic          slot_last;
	slot_kind_t    kind_n;
	tag_t          tag_n;
	logic          req_acc;

	assign t_in      = (request.param_t > T_ONE) ? T_ONE : request.param_t;
	assign slot_last = (cmd_s1 == CMD_EVAL) || (cnt_s1 == CNT_LAST);
	assign request.ready = !v_s1 || (rdy_s2 && slot_last);
	assign req_acc   = request.valid && request.ready;

	// split order: P0, L1, L2, M | M, R1, R2, P3
	always_comb begin
		tag_n.half = 1'b0;
		tag_n.idx  = '0;
		tag_n.last = slot_last;
		kind_n     = K_CUB;
		if (cmd_s1 == CMD_SPLIT) begin
			tag_n.half = cnt_s1[2];
			tag_n.idx  = cnt_s1[IDX_W-1:0];
			case (cnt_s1)
				3'd0:    kind_n = K_PASS0;
				3'd1:    kind_n = K_LIN1;
				3'd2:    kind_n = K_QUAD1;
				3'd3:    kind_n = K_CUB;
				3'd4:    kind_n = K_CUB;
				3'd5:    kind_n = K_QUAD2;
				3'd6:    kind_n = K_LIN2;
				default: kind_n = K_PASS3;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cnt_s1 <= '0;
		end else if (req_acc) begin
			v_s1   <= 1'b1;
			cnt_s1 <= '0;
		end else if (v_s1 && rdy_s2) begin
			if (slot_last) v_s1 <= 1'b0;
			else           cnt_s1 <= cnt_s1 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1 <= request.cmd;
			t_s1   <= t_in;
			u_s1   <= T_ONE - t_in;
		end
	end

	// ---------------- stage 2: products of t and 1-t ----------------
	slot_kind_t    kind_s2;
	tag_t          tag_s2;
	logic [TW-1:0] t_s2, u_s2;
	logic [SW-1:0] ut_s2, t2_s2, u2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			kind_s2 <= kind_n;
			tag_s2  <= tag_n;
			t_s2    <= t_s1;
			u_s2    <= u_s1;
			ut_s2   <= u_s1 * t_s1;
			t2_s2   <= t_s1 * t_s1;
			u2_s2   <= u_s1 * u_s1;
		end
	end

	// ---------------- stage 3: weights, all scaled to sum 2^NSH ----------------
	// Linear and quadratic weights are shifted up so one rounding shift serves all.
	tag_t          tag_s3;
	logic [WW-1:0] w_s3 [NUM_POINTS];
	logic [WW-1:0] w_n  [NUM_POINTS];
	logic [SW+1:0]       ut3;
	logic [SW+TW-1:0]    m_uuu, m_ttt;
	logic [SW+TW+1:0]    m_utu, m_utt;
	logic [SW+T_FRAC_BITS-1:0]   s_u2, s_t2;
	logic [SW+T_FRAC_BITS:0]     s_2ut;
	logic [WW-1:0]       l_u, l_t;

	always_comb begin
		ut3   = {2'b00, ut_s2} + {1'b0, ut_s2, 1'b0};
		m_uuu = u2_s2 * u_s2;
		m_ttt = t2_s2 * t_s2;
		m_utu = ut3 * u_s2;
		m_utt = ut3 * t_s2;
		s_u2  = {u2_s2, {T_FRAC_BITS{1'b0}}};
		s_t2  = {t2_s2, {T_FRAC_BITS{1'b0}}};
		s_2ut = {ut_s2, 1'b0, {T_FRAC_BITS{1'b0}}};
		l_u   = {u_s2, {(2*T_FRAC_BITS){1'b0}}};
		l_t   = {t_s2, {(2*T_FRAC_BITS){1'b0}}};
		for (int i = 0; i < NUM_POINTS; i++) w_n[i] = '0;
		case (kind_s2)
			K_PASS0: w_n[0] = W_ONE;
			K_PASS3: w_n[3] = W_ONE;
			K_LIN1: begin
				w_n[0] = l_u;
				w_n[1] = l_t;
			end
			K_LIN2: begin
				w_n[2] = l_u;
				w_n[3] = l_t;
			end
			K_QUAD1: begin
				w_n[0] = s_u2[WW-1:0];
				w_n[1] = s_2ut[WW-1:0];
				w_n[2] = s_t2[WW-1:0];
			end
			K_QUAD2: begin
				w_n[1] = s_u2[WW-1:0];
				w_n[2] = s_2ut[WW-1:0];
				w_n[3] = s_t2[WW-1:0];
			end
			K_CUB: begin
				w_n[0] = m_uuu[WW-1:0];
				w_n[1] = m_utu[WW-1:0];
				w_n[2] = m_utt[WW-1:0];
				w_n[3] = m_ttt[WW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy_s3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			tag_s3 <= tag_s2;
			for (int i = 0; i < NUM_POINTS; i++) w_s3[i] <= w_n[i];
		end
	end

	// ---------------- stage 4: weight times offset-binary coordinate ----------------
	tag_t                   tag_s4;
	logic [PW-1:0]          p_s4 [NUM_AXES][NUM_POINTS];
	logic [COORD_WIDTH-1:0] cb_n [NUM_AXES][NUM_POINTS];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++)
			for (int i = 0; i < NUM_POINTS; i++)
				cb_n[a][i] = ctrl_q[i][a*COORD_WIDTH +: COORD_WIDTH] ^ CBIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (rdy_s4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			tag_s4 <= tag_s3;
			for (int a = 0; a < NUM_AXES; a++)
				for (int i = 0; i < NUM_POINTS; i++)
					p_s4[a][i] <= w_s3[i] * cb_n[a][i];
		end
	end

	// ---------------- stage 5: sum, round half up, clamp, remove bias ----------------
	tag_t                   tag_s5;
	logic [COORD_WIDTH-1:0] crd_s5 [NUM_AXES];
	logic [COORD_WIDTH-1:0] crd_n  [NUM_AXES];
	logic [AW-1:0]          acc;
	logic [VW-1:0]          vq;

	always_comb begin
		acc = '0;
		vq  = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			acc = AW'(p_s4[a][0]) + AW'(p_s4[a][1]) + AW'(p_s4[a][2]) + AW'(p_s4[a][3]) + RND;
			vq  = acc[AW-1:NSH];
			if (|vq[VW-1:COORD_WIDTH]) crd_n[a] = {COORD_WIDTH{1'b1}} ^ CBIAS;
			else                       crd_n[a] = vq[COORD_WIDTH-1:0] ^ CBIAS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (rdy_s5) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			tag_s5 <= tag_s4;
			for (int a = 0; a < NUM_AXES; a++) crd_s5[a] <= crd_n[a];
		end
	end

	assign result.valid       = v_s5;
	assign result.coord_x     = crd_s5[0];
	assign result.coord_y     = crd_s5[1];
	assign result.coord_z     = crd_s5[2];
	assign result.half_select = tag_s5.half;
	assign result.point_index = tag_s5.idx;
	assign result.last_result = tag_s5.last;

	// ---------------- checks ----------------
	a_eval_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (cmd_s1 == CMD_EVAL) |-> cnt_s1 == 3'd0)
		else $error("evaluate transaction with nonzero slot count");

	a_split_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (cmd_s1 == CMD_SPLIT) && rdy_s2 && (cnt_s1 != CNT_LAST)
		|=> v_s1 && (cnt_s1 == $past(cnt_s1) + 3'd1))
		else $error("split expander skipped or repeated a slot");

	a_last_is_p3: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last_result && result.half_select
		|-> result.point_index == 2'd3)
		else $error("split closed on a point other than P3");

	a_first_half_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.half_select && (result.point_index != 2'd0)
		|-> !result.last_result)
		else $error("first-half point marked as last");

endmodule

>>> tb/cubic_bezier_eval_split_tb.sv
// Self-checking testbench for the cubic Bezier evaluate and split unit
`timescale 1ns / 1ps

module cubic_bezier_eval_split_tb;
	import cbes_pkg::*;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] CP_START   = 2'd0;
	localparam logic [IDX_W-1:0] CP_HANDLE1 = 2'd1;
	localparam logic [IDX_W-1:0] CP_HANDLE2 = 2'd2;
	localparam logic [IDX_W-1:0] CP_END     = 2'd3;

	// Coordinate axes inside a packed register
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// Pass index that copies no control point, so the weights are blended
	localparam int NO_PASS = -1;

	localparam logic FIRST_HALF  = 1'b0;
	localparam logic SECOND_HALF = 1'b1;

	// Result-side stall patterns
	localparam int RX_FREE   = 0;
	localparam int RX_HALF   = 1;
	localparam int RX_MOSTLY = 2;
	localparam int RX_SPARSE = 3;

	localparam int ONE_T = 1 << T_FRAC_BITS;

	localparam logic [COORD_WIDTH-1:0] COORD_MIN = CBIAS;
	localparam logic [COORD_WIDTH-1:0] COORD_MAX = ~CBIAS;

	// Exact products need about 3f + W + 2 bits; 80 leaves plenty of room
	typedef bit [79:0] wide_t;
	typedef wide_t [NUM_POINTS-1:0] weight_set_t;

	localparam wide_t COORD_MASK = (wide_t'(1) << COORD_WIDTH) - 1;

	typedef struct packed {
		cmd_t               cmd;
		logic [T_FRAC_BITS:0] t;
	} curve_request_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          half;
		logic [IDX_W-1:0]              idx;
		logic                          last;
	} curve_point_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	cbes_req_if req_bus ();
	cbes_rsp_if pt_bus ();

	cubic_bezier_eval_split dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.request   (req_bus),
		.result    (pt_bus)
	);

	// Shadow of the control point registers, updated as they are written
	logic [REG_W-1:0] cp_mirror [NUM_POINTS];

	curve_request_t queued_requests [$];  // waiting for the driver
	curve_point_t   due_points [$];       // predicted, not yet seen

	int  results_due;      // points predicted so far
	int  results_seen;     // points received so far
	int  mismatch_count;
	bit  req_taken;        // request transaction at the last rising edge
	bit  calm;             // no gaps and no stalls while set
	int  hold_cycles;      // long result-side hold-off, counted down by the receiver

	int  burst_left;
	int  gap_left;
	int  rx_tick;
	int  rx_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("cubic_bezier_eval_split regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input integer got, input integer want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Curve point predictor
	// ------------------------------------------------------------------

	// Blend one axis of the four control points with weights summing to 2^shift.
	// Coordinates are taken offset-binary so every product is unsigned; the sum
	// is rounded half-up, clamped, then the bias is flipped back.
	function automatic logic [COORD_WIDTH-1:0] blend_axis(input weight_set_t wt,
		input int shift, input int axis);
		wide_t acc;
		wide_t biased;
		int    i;
		acc = '0;
		for (i = 0; i < NUM_POINTS; i++) begin
			biased = wide_t'(cp_mirror[i][axis*COORD_WIDTH +: COORD_WIDTH] ^ CBIAS);
			acc = acc + wt[i] * biased;
		end
		acc = acc + (wide_t'(1) << (shift - 1));
		acc = acc >> shift;
		if (acc > COORD_MASK)
			acc = COORD_MASK;
		return acc[COORD_WIDTH-1:0] ^ CBIAS;
	endfunction

	function automatic curve_point_t make_point(input weight_set_t wt, input int shift,
		input int pass, input logic half, input logic [IDX_W-1:0] idx, input logic last);
		curve_point_t p;
		if (pass != NO_PASS) begin
			// end points of a split go straight through
			p.x = cp_mirror[pass][AX_X*COORD_WIDTH +: COORD_WIDTH];
			p.y = cp_mirror[pass][AX_Y*COORD_WIDTH +: COORD_WIDTH];
			p.z = cp_mirror[pass][AX_Z*COORD_WIDTH +: COORD_WIDTH];
		end else begin
			p.x = blend_axis(wt, shift, AX_X);
			p.y = blend_axis(wt, shift, AX_Y);
			p.z = blend_axis(wt, shift, AX_Z);
		end
		p.half = half;
		p.idx  = idx;
		p.last = last;
		return p;
	endfunction

	// Queues the points one request yields and returns how many
	function automatic int predict_curve_points(input cmd_t cmd,
		input logic [T_FRAC_BITS:0] raw_t);
		wide_t       one;
		wide_t       t;
		wide_t       u;
		weight_set_t cub;
		weight_set_t lin1;
		weight_set_t quad1;
		weight_set_t quad2;
		weight_set_t lin2;
		one = wide_t'(1) << T_FRAC_BITS;
		t = wide_t'(raw_t);
		if (t > one)
			t = one;  // t above one is clamped to the curve end
		u = one - t;

		// Bernstein weights, Q.3f
		cub[0] = u * u * u;
		cub[1] = 3 * u * t * u;
		cub[2] = 3 * u * t * t;
		cub[3] = t * t * t;

		if (cmd == CMD_EVAL) begin
			due_points.push_back(make_point(cub, NSH, NO_PASS, FIRST_HALF, 2'd0, 1'b1));
			return 1;
		end

		// de Casteljau levels expressed as direct weights on P0..P3
		lin1  = {wide_t'(0), wide_t'(0), t, u};
		quad1 = {wide_t'(0), t * t, 2 * u * t, u * u};
		quad2 = {t * t, 2 * u * t, u * u, wide_t'(0)};
		lin2  = {t, u, wide_t'(0), wide_t'(0)};

		due_points.push_back(make_point(cub, 0, CP_START, FIRST_HALF, 2'd0, 1'b0));
		due_points.push_back(make_point(lin1, T_FRAC_BITS, NO_PASS, FIRST_HALF, 2'd1, 1'b0));
		due_points.push_back(make_point(quad1, 2*T_FRAC_BITS, NO_PASS, FIRST_HALF, 2'd2,
			1'b0));
		due_points.push_back(make_point(cub, NSH, NO_PASS, FIRST_HALF, 2'd3, 1'b0));
		due_points.push_back(make_point(cub, NSH, NO_PASS, SECOND_HALF, 2'd0, 1'b0));
		due_points.push_back(make_point(quad2, 2*T_FRAC_BITS, NO_PASS, SECOND_HALF, 2'd1,
			1'b0));
		due_points.push_back(make_point(lin2, T_FRAC_BITS, NO_PASS, SECOND_HALF, 2'd2, 1'b0));
		due_points.push_back(make_point(cub, 0, CP_END, SECOND_HALF, 2'd3, 1'b1));
		return 8;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: bursts of random length, random gaps between them.
	// Drives on the falling edge; req_taken says whether the item on the bus
	// went through at the rising edge just gone.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_requests
		curve_request_t next_req;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || req_taken) begin
			if (!calm && gap_left > 0) begin
				gap_left = gap_left - 1;
				req_bus.valid <= 1'b0;
			end else if (queued_requests.size() != 0) begin
				next_req = queued_requests.pop_front();
				req_bus.valid   <= 1'b1;
				req_bus.cmd     <= next_req.cmd;
				req_bus.param_t <= next_req.t;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 16);
				burst_left = burst_left - 1;
				if (burst_left == 0 && !calm)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: stall pattern reshuffled periodically from rx_tick, plus an
	// optional long hold-off that lets the pipeline fill and back up.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			pt_bus.ready <= 1'b0;
		end else begin
			rx_tick = rx_tick + 1;
			if (rx_tick % 48 == 0)
				rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
			if (hold_cycles > 0) begin
				pt_bus.ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (calm) begin
				pt_bus.ready <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FREE:   pt_bus.ready <= 1'b1;
					RX_HALF:   pt_bus.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: pt_bus.ready <= ($urandom_range(0, 9) != 0);
					default:   pt_bus.ready <= (rx_tick % 4 == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each request transaction, checks each result
	// transaction against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		curve_point_t want;
		int           n;
		if (arst_n) begin
			req_taken <= req_bus.valid && req_bus.ready;
			if (req_bus.valid && req_bus.ready) begin
				n = predict_curve_points(cmd_t'(req_bus.cmd), req_bus.param_t);
				results_due <= results_due + n;
			end
			if (pt_bus.valid && pt_bus.ready) begin
				results_seen <= results_seen + 1;
				if (due_points.size() == 0) begin
					flag_mismatch("result transaction with nothing outstanding");
				end else begin
					want = due_points.pop_front();
					compare_field("coord_x", pt_bus.coord_x, want.x);
					compare_field("coord_y", pt_bus.coord_y, want.y);
					compare_field("coord_z", pt_bus.coord_z, want.z);
					compare_field("half_select", pt_bus.half_select, want.half);
					compare_field("point_index", pt_bus.point_index, want.idx);
					compare_field("last_result", pt_bus.last_result, want.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Returns at a rising edge once nothing is queued, offered or in flight
	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_requests.size() != 0 || req_bus.valid || results_due != results_seen);
	endtask

	// Only called while the unit is idle
	task automatic write_point(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		cp_mirror[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_points(input logic [REG_W-1:0] p0, input logic [REG_W-1:0] p1,
		input logic [REG_W-1:0] p2, input logic [REG_W-1:0] p3);
		write_point(CP_START, p0);
		write_point(CP_HANDLE1, p1);
		write_point(CP_HANDLE2, p2);
		write_point(CP_END, p3);
		@(posedge clk);
	endtask

	task automatic queue_request(input cmd_t c, input logic [T_FRAC_BITS:0] t);
		curve_request_t r;
		r.cmd = c;
		r.t   = t;
		queued_requests.push_back(r);
	endtask

	function automatic logic [REG_W-1:0] pack_xyz(input logic [COORD_WIDTH-1:0] x,
		input logic [COORD_WIDTH-1:0] y, input logic [COORD_WIDTH-1:0] z);
		return {z, y, x};
	endfunction

	// Random coordinate, leaning on the range ends and zero
	function automatic logic [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return '0;
			3:       return COORD_WIDTH'($urandom_range(0, 15)) - COORD_WIDTH'(8);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic [REG_W-1:0] rand_point();
		return pack_xyz(rand_coord(), rand_coord(), rand_coord());
	endfunction

	// Interesting t values: ends, near-ends, a third, halfway, and beyond one
	function automatic logic [T_FRAC_BITS:0] corner_param(input int k);
		case (k)
			0:       return '0;
			1:       return TW'(1);
			2:       return TW'(ONE_T / 3);
			3:       return TW'(ONE_T / 2);
			4:       return TW'(ONE_T - 1);
			5:       return TW'(ONE_T);
			6:       return TW'(ONE_T + 1);
			default: return TW'(2 * ONE_T - 1);
		endcase
	endfunction

	function automatic logic [T_FRAC_BITS:0] rand_param();
		case ($urandom_range(0, 9))
			0:       return corner_param($urandom_range(0, 7));
			1:       return TW'($urandom_range(ONE_T + 1, 2 * ONE_T - 1));
			default: return TW'($urandom_range(0, ONE_T));
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		return ($urandom_range(0, 4) < 2) ? CMD_SPLIT : CMD_EVAL;
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int ph;
		int k;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		req_bus.valid   = 1'b0;
		req_bus.cmd     = 1'b0;
		req_bus.param_t = '0;
		pt_bus.ready    = 1'b0;
		req_taken       = 1'b0;
		calm            = 1'b1;
		hold_cycles     = 0;
		results_due     = 0;
		results_seen    = 0;
		mismatch_count  = 0;
		burst_left      = 0;
		gap_left        = 0;
		rx_tick         = 0;
		rx_mode         = RX_FREE;
		for (k = 0; k < NUM_POINTS; k++)
			cp_mirror[k] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Control points straight out of reset: every result must be zero
		queue_request(CMD_EVAL, TW'(ONE_T / 2));
		queue_request(CMD_SPLIT, TW'(ONE_T / 3));
		queue_request(CMD_EVAL, TW'(ONE_T));
		wait_drained();

		// Directed: opposing corners of the coordinate cube, each corner t
		// value through both commands, clamped t values included
		load_points(pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN),
			pack_xyz(COORD_MAX, COORD_MIN, COORD_MAX),
			pack_xyz(COORD_MIN, COORD_MAX, COORD_MIN),
			pack_xyz(COORD_MAX, COORD_MAX, COORD_MAX));
		calm = 1'b0;
		for (k = 0; k < 8; k++) begin
			queue_request(CMD_EVAL, corner_param(k));
			queue_request(CMD_SPLIT, corner_param(k));
		end
		wait_drained();

		// Random phases, fresh control points in each
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_points(pack_xyz(COORD_MAX, COORD_MAX, COORD_MAX),
					pack_xyz(COORD_MAX, COORD_MAX, COORD_MAX),
					pack_xyz(COORD_MAX, COORD_MAX, COORD_MAX),
					pack_xyz(COORD_MAX, COORD_MAX, COORD_MAX));
				1: load_points(pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN),
					pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN),
					pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN),
					pack_xyz(COORD_MIN, COORD_MIN, COORD_MIN));
				default: load_points(rand_point(), rand_point(), rand_point(), rand_point());
			endcase

			// one phase runs flat out with no gaps or stalls
			calm = (ph == 2);

			for (k = 0; k < 39; k++) begin
				queue_request(rand_cmd(), rand_param());
				// sender holds back here until every point so far has come out
				if (ph == 4 && k == 19) begin
					@(posedge clk);
					wait_drained();
				end
			end

			// results held off long enough for the pipeline to back up into
			// the request side while the driver keeps offering
			if (ph == 3)
				hold_cycles = 400;

			wait_drained();
		end

		// Allow for anything stray still working through the pipeline
		repeat (12) @(posedge clk);
		if (due_points.size() != 0)
			flag_mismatch($sformatf("%0d predicted points never arrived", due_points.size()));

		if (mismatch_count == 0) begin
			$display("cubic_bezier_eval_split regression: pass");
		end else begin
			$display("cubic_bezier_eval_split regression: fail");
		end
		$finish;
	end

endmodule
